// ===== rtl/assert_macros.svh =====
// ------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the rtl, clocked on clk
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge outside reset
`define PRP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define PRP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/prp_pkg.sv =====
// ------------------------------------------------------------------------
// prp_pkg
// types, constants and helpers of the page replacement policy engine
// ------------------------------------------------------------------------
package prp_pkg;

	localparam int MAX_FRAMES = 128;
	localparam int AGE_BITS   = 8;
	localparam int PAGE_W     = 32;
	localparam int ADDR_W     = 32;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int LEAD_W     = $clog2(AGE_BITS) + 1;
	localparam int LEAD_OLD   = 4;
	localparam int LEAD_GAP   = 3;
	localparam int AGEC_W     = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int IN_W       = 40;
	localparam int OUT_W      = 136;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

	// policy modes
	localparam logic [1:0] MODE_SC     = 2'd0;
	localparam logic [1:0] MODE_ESC    = 2'd1;
	localparam logic [1:0] MODE_AGING  = 2'd2;
	localparam logic [1:0] MODE_EAGING = 2'd3;

	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [PAGE_W-1:0]   page;
		logic                dirty;
		logic                refb;
		logic [AGE_BITS-1:0] age;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOK,
		ST_APPEND,
		ST_VSCAN,
		ST_VDEC,
		ST_VREAD,
		ST_VGET,
		ST_REBUILD,
		ST_RNEW,
		ST_ACHK,
		ST_AGE,
		ST_DONE
	} state_t;

	// zero bits above the highest one bit; all ones when the age is zero
	function automatic logic [LEAD_W-1:0] age_lead(input logic [AGE_BITS-1:0] age);
		logic [LEAD_W-1:0] res;
		res = '1;
		for (int p = 0; p < AGE_BITS; p++) begin
			if (age[p]) begin
				res = LEAD_W'(AGE_BITS - 1 - p);
			end
		end
		return res;
	endfunction

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == SAT32) ? v : v + 32'd1;
	endfunction

endpackage

// ===== rtl/page_replacement_policy_top.sv =====
// ------------------------------------------------------------------------
// page_replacement_policy_top
// frame table engine with second chance and aging replacement policies
// ------------------------------------------------------------------------
// One access beat (write flag, byte address) goes in, one result beat comes
// out. The frame table sits in two banks of ram; a single compare unit walks
// it one entry per cycle under a sequencer, and the block takes no new beat
// until the access has finished. A hit costs a walk of the occupied frames.
// A miss with room adds an append step; a full table adds a victim walk
// (one pass for second chance and the aging modes, up to four for
// enhanced second chance), a rebuild pass into the other bank and, when
// an aging tick falls due, an aging pass. Aging ticks only happen in the
// aging modes, so the worst case is enhanced second chance. The ram read
// port sets the pace of these walks. A finished result waits in the output
// register, and the next beat is accepted meanwhile. No clearing pass is
// needed after reset.
`include "assert_macros.svh"

module page_replacement_policy_top
	import prp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// access beats
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_W-1:0]       s_tdata,   // is_write, address, zero pad
	// result beats
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_W-1:0]      m_tdata,   // hit, evicted, evicted_dirty,
	                                         // evicted_page, access_count,
	                                         // disk_reads, disk_writes, pad
	// register writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q, state_d;

	// configuration
	logic [1:0]        mode_q;
	logic [7:0]        frames_q;
	logic [4:0]        offset_q;
	logic [AGEC_W-1:0] interval_q;

	// table state and totals
	logic              cur_q;      // bank holding the table
	logic [CNT_W-1:0]  occ_q;
	logic [AGEC_W-1:0] agec_q;
	logic [31:0]       acc_q, miss_q, wb_q;

	// current access
	logic              wr_q;
	logic [PAGE_W-1:0] page_q;
	logic              hit_q, ev_q, evd_q;
	logic [PAGE_W-1:0] evp_q;

	// walk control
	logic [CNT_W-1:0]  cnt_q;
	logic [1:0]        pass_q;
	logic              valid_s1, clr_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [IDX_W-1:0]  v_q;
	logic [CNT_W-1:0]  clrlim_q;

	// aging victim trackers
	logic                fa_q, fr_q, fw_q, hasc_q, hasd_q;
	logic [IDX_W-1:0]    ia_q, ir_q, iw_q;
	logic [AGE_BITS-1:0] aa_q, ar_q, aw_q, age0_q;

	// output register
	logic              m_valid_q;
	logic [OUT_W-1:0]  m_data_q;

	// ram ports
	logic              wr_en, wr_bank;
	logic [IDX_W-1:0]  wr_addr, rd_addr;
	entry_t            wr_ent, rdata, rd0, rd1;

	logic              accept, issue, pass_adv, match, last, pred, shift;
	logic [CNT_W-1:0]  limit, n_m1;
	logic [CNT_W:0]    src;
	logic [AGEC_W-1:0] agec_inc;
	logic [IDX_W-1:0]  v_dec;
	logic [IDX_W-1:0]  r_idx, w_idx;
	logic [AGE_BITS-1:0] r_age, w_age;
	logic [LEAD_W-1:0] lr, lw;
	logic              sel_r;
	entry_t            new_ent;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign rdata     = cur_q ? rd1 : rd0;

	// frame limit, zero acts as one, clipped to the table size
	always_comb begin
		if (frames_q == 8'd0) begin
			limit = CNT_W'(1);
		end else if (32'(frames_q) > MAX_FRAMES) begin
			limit = CNT_W'(MAX_FRAMES);
		end else begin
			limit = CNT_W'(frames_q);
		end
	end

	assign n_m1     = occ_q - CNT_W'(1);
	assign last     = valid_s1 && (CNT_W'(idx_s1) == n_m1);
	assign match    = valid_s1 && (rdata.page == page_q);
	assign agec_inc = agec_q + AGEC_W'(1);
	assign shift    = mode_q[1] && (interval_q != '0) && (agec_inc == interval_q);
	assign new_ent  = '{page: page_q, dirty: wr_q, refb: 1'b1, age: '0};

	// victim test for the two second chance modes
	always_comb begin
		case (mode_q)
			MODE_SC: pred = !rdata.refb;
			MODE_ESC: begin
				case (pass_q)
					2'd0:    pred = !rdata.refb && !rdata.dirty;
					2'd1:    pred = !rdata.refb && rdata.dirty;
					2'd2:    pred = !rdata.dirty;
					default: pred = rdata.dirty;
				endcase
			end
			default: pred = 1'b0;
		endcase
	end

	// rebuild source: wrapped order after the victim, or the victim dropped
	always_comb begin
		src = '0;
		if (!mode_q[1]) begin
			src = (CNT_W+1)'(v_q) + (CNT_W+1)'(1) + (CNT_W+1)'(cnt_q);
			if (src >= (CNT_W+1)'(occ_q)) begin
				src = src - (CNT_W+1)'(occ_q);
			end
		end else if (cnt_q < CNT_W'(v_q)) begin
			src = (CNT_W+1)'(cnt_q);
		end else begin
			src = (CNT_W+1)'(cnt_q) + (CNT_W+1)'(1);
		end
	end

	// victim choice of the aging modes
	always_comb begin
		r_idx = fr_q ? ir_q : '0;
		r_age = fr_q ? ar_q : age0_q;
		w_idx = fw_q ? iw_q : '0;
		w_age = fw_q ? aw_q : age0_q;
		lr    = age_lead(r_age);
		lw    = age_lead(w_age);
		if (r_age == '0) begin
			sel_r = 1'b1;
		end else if (w_age == '0) begin
			sel_r = (lr >= LEAD_W'(LEAD_OLD));
		end else begin
			sel_r = !((LEAD_W+1)'(lw) > (LEAD_W+1)'(lr) + (LEAD_W+1)'(LEAD_GAP));
		end
		if (mode_q == MODE_AGING || !(hasc_q && hasd_q)) begin
			v_dec = fa_q ? ia_q : '0;
		end else begin
			v_dec = sel_r ? r_idx : w_idx;
		end
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		pass_adv = 1'b0;
		rd_addr  = cnt_q[IDX_W-1:0];
		wr_en    = 1'b0;
		wr_bank  = cur_q;
		wr_addr  = idx_s1;
		wr_ent   = rdata;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (match) begin
					wr_en        = 1'b1;
					wr_ent.refb  = 1'b1;
					wr_ent.dirty = rdata.dirty | wr_q;
					state_d      = ST_ACHK;
				end else if (occ_q == '0 || last) begin
					state_d = (occ_q < limit) ? ST_APPEND : ST_VSCAN;
				end else begin
					issue = (cnt_q < occ_q);
				end
			end
			ST_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = occ_q[IDX_W-1:0];
				wr_ent  = new_ent;
				state_d = ST_ACHK;
			end
			ST_VSCAN: begin
				if (mode_q[1]) begin
					if (last) begin
						state_d = ST_VDEC;
					end else begin
						issue = (cnt_q < occ_q);
					end
				end else if (valid_s1 && pred) begin
					state_d = ST_VREAD;
				end else if (last) begin
					if (mode_q == MODE_ESC && pass_q != 2'd3) begin
						pass_adv = 1'b1;
					end else begin
						state_d = ST_VREAD;
					end
				end else begin
					issue = (cnt_q < occ_q);
				end
			end
			ST_VDEC: state_d = ST_VREAD;
			ST_VREAD: begin
				rd_addr = v_q;
				state_d = ST_VGET;
			end
			ST_VGET: state_d = (occ_q > CNT_W'(1)) ? ST_REBUILD : ST_RNEW;
			ST_REBUILD: begin
				rd_addr = src[IDX_W-1:0];
				issue   = (cnt_q < n_m1);
				wr_bank = ~cur_q;
				if (valid_s1) begin
					wr_en = 1'b1;
					if (clr_s1) begin
						wr_ent.refb = 1'b0;
					end
					if (CNT_W'(idx_s1) == n_m1 - CNT_W'(1)) begin
						state_d = ST_RNEW;
					end
				end
			end
			ST_RNEW: begin
				wr_en   = 1'b1;
				wr_bank = ~cur_q;
				wr_addr = n_m1[IDX_W-1:0];
				wr_ent  = new_ent;
				state_d = ST_ACHK;
			end
			ST_ACHK: state_d = shift ? ST_AGE : ST_DONE;
			ST_AGE: begin
				if (valid_s1) begin
					wr_en       = 1'b1;
					wr_ent.age  = {rdata.refb, rdata.age[AGE_BITS-1:1]};
					wr_ent.refb = 1'b0;
				end
				if (last) begin
					state_d = ST_DONE;
				end else begin
					issue = (cnt_q < occ_q);
				end
			end
			ST_DONE: begin
				if (!m_valid_q || m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_SC;
			frames_q   <= 8'd4;
			offset_q   <= 5'd12;
			interval_q <= '0;
			cur_q      <= 1'b0;
			occ_q      <= '0;
			agec_q     <= '0;
			acc_q      <= '0;
			miss_q     <= '0;
			wb_q       <= '0;
			cnt_q      <= '0;
			pass_q     <= '0;
			valid_s1   <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_POLICY:   mode_q     <= cfg_data[1:0];
					CFG_FRAMES:   frames_q   <= cfg_data[7:0];
					CFG_OFFSET:   offset_q   <= cfg_data[4:0];
					CFG_INTERVAL: interval_q <= cfg_data;
					default:      mode_q     <= mode_q;
				endcase
			end
			valid_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_d != state_q || pass_adv) begin
				cnt_q <= '0;
			end
			if (accept) begin
				pass_q <= '0;
				acc_q  <= sat_inc(acc_q);
			end else if (pass_adv) begin
				pass_q <= pass_q + 2'd1;
			end
			if (state_q == ST_LOOK && !match && (occ_q == '0 || last)) begin
				miss_q <= sat_inc(miss_q);
			end
			if (state_q == ST_APPEND) begin
				occ_q <= occ_q + CNT_W'(1);
			end
			if (state_q == ST_VGET && rdata.dirty) begin
				wb_q <= sat_inc(wb_q);
			end
			if (state_q == ST_RNEW) begin
				cur_q <= ~cur_q;
			end
			if (state_q == ST_ACHK && mode_q[1]) begin
				agec_q <= shift ? '0 : agec_inc;
			end
			if (state_q == ST_DONE && state_d == ST_IDLE) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IDX_W-1:0];
		clr_s1 <= (src < (CNT_W+1)'(clrlim_q));
		if (accept) begin
			wr_q   <= s_tdata[0];
			page_q <= s_tdata[ADDR_W:1] >> offset_q;
			hit_q  <= 1'b0;
			ev_q   <= 1'b0;
			evd_q  <= 1'b0;
			evp_q  <= '0;
			fa_q   <= 1'b0;
			fr_q   <= 1'b0;
			fw_q   <= 1'b0;
			hasc_q <= 1'b0;
			hasd_q <= 1'b0;
		end
		if (state_q == ST_LOOK && match) begin
			hit_q <= 1'b1;
		end
		// victim walk of the second chance modes
		if (state_q == ST_VSCAN && !mode_q[1]) begin
			if (valid_s1 && pred) begin
				v_q <= idx_s1;
				if (mode_q == MODE_SC || pass_q == 2'd1) begin
					clrlim_q <= CNT_W'(idx_s1);
				end else if (pass_q == 2'd0) begin
					clrlim_q <= '0;
				end else begin
					clrlim_q <= occ_q;
				end
			end else begin
				v_q      <= '0;
				clrlim_q <= occ_q;
			end
		end
		// minimum age trackers of the aging modes
		if (state_q == ST_VSCAN && mode_q[1] && valid_s1) begin
			if (idx_s1 == '0) begin
				age0_q <= rdata.age;
			end
			if (rdata.dirty) begin
				hasd_q <= 1'b1;
			end else begin
				hasc_q <= 1'b1;
			end
			if (!rdata.refb) begin
				if (!fa_q || rdata.age < aa_q) begin
					fa_q <= 1'b1;
					ia_q <= idx_s1;
					aa_q <= rdata.age;
				end
				if (!rdata.dirty && (!fr_q || rdata.age < ar_q)) begin
					fr_q <= 1'b1;
					ir_q <= idx_s1;
					ar_q <= rdata.age;
				end
				if (rdata.dirty && (!fw_q || rdata.age < aw_q)) begin
					fw_q <= 1'b1;
					iw_q <= idx_s1;
					aw_q <= rdata.age;
				end
			end
		end
		if (state_q == ST_VDEC) begin
			v_q      <= v_dec;
			clrlim_q <= '0;
		end
		if (state_q == ST_VGET) begin
			ev_q  <= 1'b1;
			evd_q <= rdata.dirty;
			evp_q <= rdata.page;
		end
		if (state_q == ST_DONE && state_d == ST_IDLE) begin
			m_data_q <= {5'd0, wb_q, miss_q, acc_q, evp_q, evd_q, ev_q, hit_q};
		end
	end

	// table banks, the rebuild pass moves the table to the other bank
	prp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_FRAMES)
	) u_bank0 (
		.clk   (clk),
		.we    (wr_en && !wr_bank),
		.waddr (wr_addr),
		.wdata (wr_ent),
		.raddr (rd_addr),
		.rdata (rd0)
	);

	prp_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_FRAMES)
	) u_bank1 (
		.clk   (clk),
		.we    (wr_en && wr_bank),
		.waddr (wr_addr),
		.wdata (wr_ent),
		.raddr (rd_addr),
		.rdata (rd1)
	);

	`PRP_ASSERT(a_occ_bound, (32'(occ_q) <= MAX_FRAMES), "occupancy beyond table size")
	`PRP_ASSERT(a_miss_le_acc, (miss_q <= acc_q && wb_q <= miss_q), "totals out of order")
	`PRP_ASSERT(a_accept_starts, (accept |=> state_q == ST_LOOK), "accepted beat not walked")
	`PRP_ASSERT(a_walk_in_table, (valid_s1 |-> CNT_W'(idx_s1) < occ_q), "walk past occupied frames")

endmodule

// ===== rtl/prp_ram.sv =====
// ------------------------------------------------------------------------
// prp_ram
// generic simple dual port ram, one write port, registered read
// ------------------------------------------------------------------------
module prp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
